/* design/cat2_pkg.sv */
package cat2_pkg;

   // Datapath sizing
   localparam int ROTATIONS   = 24;
   localparam int COORD_WIDTH = 32;
   localparam int IN_W        = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int XY_W        = COORD_WIDTH + 2;
   localparam int ANGLE_W     = 32;
   localparam int IDX_W       = $clog2(ROTATIONS);
   localparam int TABLE_LEN   = 30;
   localparam int TABLE_IDX_W = $clog2(TABLE_LEN);

   typedef logic signed [XY_W-1:0]    xy_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   // pi and pi/2 in Q2.29
   localparam angle_type PI_Q      = 32'sd1686629713;
   localparam angle_type HALF_PI_Q = 32'sd843314857;

   // round(atan(2^-i) * 2^29)
   localparam angle_type ATAN_TABLE [TABLE_LEN] = '{
      32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579, 32'sd33510843,
      32'sd16771758,  32'sd8387925,   32'sd4194219,   32'sd2097141,  32'sd1048575,
      32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,
      32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,
      32'sd512,       32'sd256,       32'sd128,       32'sd64,       32'sd32,
      32'sd16,        32'sd8,         32'sd4,         32'sd2,        32'sd1
   };

   // One item in flight between two pipeline stages
   typedef struct packed {
      xy_type    x;
      xy_type    y;
      angle_type acc;
      logic      neg;    // vector was folded into the right half plane
      logic      ypos;   // original y was positive
      logic      spec;   // axis or zero vector, acc already holds the answer
   } stage_type;

   function automatic angle_type atan_entry(input logic [IDX_W-1:0] idx);
      logic [TABLE_IDX_W-1:0] t;
      t = TABLE_IDX_W'(idx);
      atan_entry = (int'(t) < TABLE_LEN) ? ATAN_TABLE[t] : '0;
   endfunction

endpackage

/* design/cat2_fold.sv */
module cat2_fold (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [31:0]                   in_y,
   input  logic [31:0]                   in_x,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cat2_pkg::stage_type           out_data
);

   logic                valid_ff, valid_in;
   cat2_pkg::stage_type data_ff, data_in, fold;
   cat2_pkg::xy_type    y, x;
   logic                xz, yz;

   always_comb begin
      y  = cat2_pkg::xy_type'(signed'(in_y[cat2_pkg::IN_W-1:0]));
      x  = cat2_pkg::xy_type'(signed'(in_x[cat2_pkg::IN_W-1:0]));
      xz = (x == '0);
      yz = (y == '0);

      fold.neg  = (x < 0);
      fold.ypos = (y > 0);
      fold.spec = xz || yz;
      fold.x    = fold.neg ? -x : x;
      fold.y    = fold.neg ? -y : y;

      if (xz && yz) begin
         fold.acc = '0;
      end else if (xz) begin
         fold.acc = (y > 0) ? cat2_pkg::HALF_PI_Q : -cat2_pkg::HALF_PI_Q;
      end else if (yz) begin
         fold.acc = (x < 0) ? cat2_pkg::PI_Q : '0;
      end else begin
         fold.acc = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_ready && in_valid) ? fold : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/cat2_rot_stage.sv */
module cat2_rot_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cat2_pkg::IDX_W-1:0]    shift,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cat2_pkg::stage_type           in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cat2_pkg::stage_type           out_data
);

   logic                valid_ff, valid_in;
   cat2_pkg::stage_type data_ff, data_in, step;
   cat2_pkg::xy_type    dx, dy;
   cat2_pkg::angle_type da;

   // One micro-rotation: drive y toward zero, steer by the sign of y
   always_comb begin
      dx   = in_data.y >>> shift;
      dy   = in_data.x >>> shift;
      da   = cat2_pkg::atan_entry(shift);
      step = in_data;
      if (!in_data.spec) begin
         if (in_data.y > 0) begin
            step.x   = in_data.x + dx;
            step.y   = in_data.y - dy;
            step.acc = in_data.acc + da;
         end else begin
            step.x   = in_data.x - dx;
            step.y   = in_data.y + dy;
            step.acc = in_data.acc - da;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_ready && in_valid) ? step : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/cat2_final.sv */
module cat2_final (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cat2_pkg::stage_type           in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cat2_pkg::angle_type           out_angle
);

   localparam int SUM_W = cat2_pkg::ANGLE_W + 1;

   logic                     valid_ff, valid_in;
   cat2_pkg::angle_type      angle_ff, angle_in, result;
   logic signed [SUM_W-1:0]  offset, sum, pi_w;

   // Undo the half-plane fold, then clamp to [-pi, pi]
   always_comb begin
      pi_w = SUM_W'(cat2_pkg::PI_Q);
      if (in_data.neg && !in_data.spec) begin
         offset = in_data.ypos ? pi_w : -pi_w;
      end else begin
         offset = '0;
      end
      sum = SUM_W'(in_data.acc) + offset;
      if (sum > pi_w) begin
         result = cat2_pkg::PI_Q;
      end else if (sum < -pi_w) begin
         result = -cat2_pkg::PI_Q;
      end else begin
         result = cat2_pkg::angle_type'(sum[cat2_pkg::ANGLE_W-1:0]);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign angle_in = (in_ready && in_valid) ? result : angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

/* design/cordic_atan2.sv */
// Four-quadrant arctangent by CORDIC vectoring. Each req transaction carries a
// signed vector (y, x) at any common scale; each rsp transaction returns
// atan2(y, x) in radians as signed Q2.29, from -pi to pi. The pipeline is
// ROTATIONS + 2 register stages deep (26 at the default 24 rotations):
// one stage folds the vector into the right half plane and catches the zero
// and on-axis cases, one stage per shift-add micro-rotation, and a final
// stage that restores the quadrant, clamps and holds the result. A new vector
// is taken every cycle while the rsp side is not stalled; each stage carries
// its own valid bit and ready is computed stage by stage, so a stalled rsp
// side fills empty slots before req_ready drops and nothing is lost or
// repeated. Internal x and y carry two guard bits and never saturate.
module cordic_atan2 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_x_coord,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle
);

   localparam int NSTAGE = cat2_pkg::ROTATIONS + 1;

   // Links between stages: link k feeds rotation k (link NSTAGE-1 feeds the final stage)
   cat2_pkg::stage_type link_data  [NSTAGE];
   logic                link_valid [NSTAGE];
   logic                link_ready [NSTAGE];

   // Fold into the right half plane, flag zero and axis vectors
   cat2_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_y      (req_y_coord),
      .in_x      (req_x_coord),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // One register stage per micro-rotation
   for (genvar i = 0; i < cat2_pkg::ROTATIONS; i++) begin : g_rot
      cat2_rot_stage u_rot (
         .clock     (clock),
         .reset     (reset),
         .shift     (cat2_pkg::IDX_W'(i)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Restore the quadrant, clamp, and hold the result for the rsp side
   cat2_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NSTAGE-1]),
      .in_ready  (link_ready[NSTAGE-1]),
      .in_data   (link_data[NSTAGE-1]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_angle (rsp_angle)
   );

`ifndef NO_ASSERTIONS
   // An output register that is empty or draining must let the whole pipe advance
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while the output stage can advance");

   // The angle never leaves [-pi, pi]
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle <= cat2_pkg::PI_Q) && (rsp_angle >= -cat2_pkg::PI_Q))
      else $error("rsp_angle outside [-pi, pi]");

   // With the output register and the final stage's input both empty, no result is reported on the next cycle
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !link_valid[NSTAGE-1]) |=> !rsp_valid)
      else $error("rsp_valid raised without an item in the last stage");
`endif

endmodule
